[sv/tts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the text console engine: character codes,
// field widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int RROW_W      = 5;
  localparam int RCOL_W      = 7;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RADDR,
    ST_RDATA,
    ST_BLANK,
    ST_DONE
  } tts_state_e;

  typedef struct packed {
    logic load_in;
    logic exec_put;
    logic rd_setup;
    logic rd_issue;
    logic rd_capture;
    logic clear_wr;
    logic blank_wr;
    logic cnt_clr;
    logic load_out;
  } tts_cmd_t;

  typedef struct packed {
    logic is_read;
    logic scroll;
    logic clear_last;
    logic blank_last;
  } tts_sts_t;

endpackage

[sv/tts_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-port RAM with one address, write enable and registered read.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ctrl
// Controller: sequences the screen clear after reset, command execution,
// cell reads, row blanking on scroll, and the output register handoff.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tts_pkg::tts_sts_t sts_i,
  output tts_pkg::tts_cmd_t cmd_o
);
  import tts_pkg::*;

  tts_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  tts_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_read) begin
          cmd.rd_setup = 1'b1;
          state_d      = ST_RADDR;
        end else begin
          cmd.exec_put = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_d      = sts_i.scroll ? ST_BLANK : ST_DONE;
        end
      end
      ST_RADDR: begin
        cmd.rd_issue = 1'b1;
        state_d      = ST_RDATA;
      end
      ST_RDATA: begin
        cmd.rd_capture = 1'b1;
        state_d        = ST_DONE;
      end
      ST_BLANK: begin
        cmd.blank_wr = 1'b1;
        if (sts_i.blank_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending beat");

  // A put that scrolls always blanks a row before reporting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.exec_put && sts_i.scroll) |=> (state_q == ST_BLANK))
    else $error("scroll without row blanking");

  // The screen clear ends in idle, ready for the first item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.clear_wr && sts_i.clear_last) |=> in_ready_o)
    else $error("clear pass did not hand over to idle");

endmodule

[sv/tts_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_dp
// Datapath: input and result registers, cursor and circular row offset,
// screen store addressing and the sweep counter for clearing and blanking.
// ----------------------------------------------------------------------------
module tts_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tts_pkg::tts_cmd_t              cmd_i,
  output tts_pkg::tts_sts_t              sts_o,
  input  logic                           cfg_we_i,
  input  logic [tts_pkg::ATTR_W-1:0]     cfg_wdata_i,
  input  logic                           in_cmd_i,
  input  logic [tts_pkg::CHAR_W-1:0]     in_char_i,
  input  logic [tts_pkg::RROW_W-1:0]     in_row_i,
  input  logic [tts_pkg::RCOL_W-1:0]     in_col_i,
  output logic [tts_pkg::CHAR_W-1:0]     out_char_o,
  output logic [tts_pkg::ATTR_W-1:0]     out_attr_o,
  output logic [tts_pkg::RROW_W-1:0]     out_row_o,
  output logic [tts_pkg::RCOL_W-1:0]     out_col_o,
  output logic                           out_scrolled_o
);
  import tts_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(DEPTH - 1);
  localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

  // Input item.
  logic              in_cmd_q;
  logic [CHAR_W-1:0] in_char_q;
  logic [RROW_W-1:0] in_row_q;
  logic [RCOL_W-1:0] in_col_q;

  // Cursor, its physical row in the store, and the store row shown on top.
  logic [RW-1:0]     cur_row_q, cur_prow_q, top_q;
  logic [CW-1:0]     cur_col_q;
  logic [ATTR_W-1:0] text_attr_q;
  logic [AW-1:0]     cnt_q;

  logic [RW-1:0]     rd_prow_q;
  logic [CW-1:0]     rd_col_q;
  logic              rd_ok_q;

  logic [CHAR_W-1:0] res_char_q, out_char_q;
  logic [ATTR_W-1:0] res_attr_q, out_attr_q;
  logic              res_scroll_q, out_scroll_q;
  logic [RROW_W-1:0] out_row_q;
  logic [RCOL_W-1:0] out_col_q;

  logic              is_cr, is_lf, printable, col_wrap, row_adv, at_bottom, scroll;
  logic [RW-1:0]     prow_inc, top_inc, rd_prow_d;
  logic [RW:0]       rd_sum;
  logic              rd_ok;
  logic [RW-1:0]     row_sel;
  logic [CW-1:0]     col_sel;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign is_cr     = (in_char_q == CH_CR);
  assign is_lf     = (in_char_q == CH_LF);
  assign printable = !is_cr && !is_lf;
  assign col_wrap  = (cur_col_q == COL_LAST);
  assign row_adv   = !is_cr && (is_lf || col_wrap);
  assign at_bottom = (cur_row_q == ROW_LAST);
  assign scroll    = row_adv && at_bottom;

  assign prow_inc = (cur_prow_q == ROW_LAST) ? '0 : cur_prow_q + RW'(1);
  assign top_inc  = (top_q == ROW_LAST) ? '0 : top_q + RW'(1);

  // Logical read row to store row: one add and one conditional subtract.
  assign rd_ok     = (32'(in_row_q) < ROWS) && (32'(in_col_q) < COLUMNS);
  assign rd_sum    = {1'b0, RW'(in_row_q)} + {1'b0, top_q};
  assign rd_prow_d = (rd_sum >= ROWS_EXT) ? RW'(rd_sum - ROWS_EXT) : RW'(rd_sum);

  always_comb begin
    row_sel = cmd_i.rd_issue ? rd_prow_q : cur_prow_q;
    if (cmd_i.rd_issue) begin
      col_sel = rd_col_q;
    end else if (cmd_i.blank_wr) begin
      col_sel = cnt_q[CW-1:0];
    end else begin
      col_sel = cur_col_q;
    end
    if (cmd_i.clear_wr) begin
      ram_addr = cnt_q;
    end else begin
      ram_addr = AW'(row_sel) * COLS_A + AW'(col_sel);
    end
    if (cmd_i.clear_wr) begin
      ram_wdata = {ATTR_RESET, CH_SPACE};
    end else if (cmd_i.blank_wr) begin
      ram_wdata = {text_attr_q, CH_SPACE};
    end else begin
      ram_wdata = {text_attr_q, in_char_q};
    end
  end

  assign ram_we = cmd_i.clear_wr || cmd_i.blank_wr || (cmd_i.exec_put && printable);
  assign ram_re = cmd_i.rd_issue && rd_ok_q;

  tts_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cur_prow_q  <= '0;
      top_q       <= '0;
      cnt_q       <= '0;
      text_attr_q <= ATTR_RESET;
    end else begin
      if (cfg_we_i) begin
        text_attr_q <= cfg_wdata_i;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_wr || cmd_i.blank_wr) begin
        cnt_q <= cnt_q + AW'(1);
      end
      if (cmd_i.exec_put) begin
        cur_col_q <= (row_adv || is_cr) ? '0 : cur_col_q + CW'(1);
        if (row_adv) begin
          // On the bottom row the cursor stays and the view moves down a row.
          // The cursor's store row advances either way.
          cur_prow_q <= prow_inc;
          if (at_bottom) begin
            top_q <= top_inc;
          end else begin
            cur_row_q <= cur_row_q + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_cmd_q  <= in_cmd_i;
      in_char_q <= in_char_i;
      in_row_q  <= in_row_i;
      in_col_q  <= in_col_i;
    end
    if (cmd_i.rd_setup) begin
      rd_prow_q <= rd_prow_d;
      rd_col_q  <= CW'(in_col_q);
      rd_ok_q   <= rd_ok;
    end
    if (cmd_i.exec_put) begin
      res_char_q   <= '0;
      res_attr_q   <= '0;
      res_scroll_q <= scroll;
    end else if (cmd_i.rd_capture) begin
      res_char_q   <= rd_ok_q ? ram_rdata[CHAR_W-1:0] : '0;
      res_attr_q   <= rd_ok_q ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      res_scroll_q <= 1'b0;
    end
    if (cmd_i.load_out) begin
      out_char_q   <= res_char_q;
      out_attr_q   <= res_attr_q;
      out_scroll_q <= res_scroll_q;
      out_row_q    <= RROW_W'(cur_row_q);
      out_col_q    <= RCOL_W'(cur_col_q);
    end
  end

  assign sts_o.is_read    = (in_cmd_q == CMD_READ);
  assign sts_o.scroll     = scroll;
  assign sts_o.clear_last = (cnt_q == CELL_LAST);
  assign sts_o.blank_last = (cnt_q[CW-1:0] == COL_LAST);

  assign out_char_o     = out_char_q;
  assign out_attr_o     = out_attr_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_scrolled_o = out_scroll_q;

  // The cursor's store row always equals its screen row plus the top offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (({1'b0, cur_row_q} + {1'b0, top_q} >= ROWS_EXT)
       ? (cur_prow_q == RW'({1'b0, cur_row_q} + {1'b0, top_q} - ROWS_EXT))
       : (cur_prow_q == RW'({1'b0, cur_row_q} + {1'b0, top_q}))))
    else $error("cursor store row out of step with top offset");

  // The cursor never leaves the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_row_q) < ROWS) && (32'(cur_col_q) < COLUMNS))
    else $error("cursor outside the screen");

  // Every store access stays inside the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we || ram_re) |-> (32'(ram_addr) < DEPTH))
    else $error("screen store address out of range");

endmodule

[sv/text_terminal_cursor_scroll.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Text-mode console: ROWS x COLUMNS character/attribute store with a cursor,
// carriage return, line feed, line wrap and scroll-up, plus cell read-back.
//
//   channel  | direction | contents
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | put character or read one cell
//   m_axis   | out       | one result beat per accepted item
//   cfg      | in        | text attribute register write
//
// A put loads the item, writes a printable character to its cell and loads the
// output; a read sets up the address, accesses the single-port screen store,
// captures the registered data and loads the output. A put that scrolls then
// blanks the new bottom row one cell a cycle. Scrolling moves a row offset;
// stored rows are never copied. After reset the store is cleared one cell a
// cycle with s_axis_tready low. A stalled m_axis holds its beat; one more item
// can be accepted and run up to its result meanwhile.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cfg_wdata_i: text_attr[7:0]
  input  logic                                cfg_we_i,
  input  logic [tts_pkg::ATTR_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: char_in[7:0], read_row[12:8], read_col[19:13], zero[23:20]
  input  logic [tts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tuser: cmd[0]
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: cell_char[7:0], cell_attr[15:8], cursor_row[20:16],
  //        cursor_col[27:21], scrolled[28], zero[31:29]
  output logic [tts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import tts_pkg::*;

  tts_cmd_t          cmd;
  tts_sts_t          sts;
  logic [CHAR_W-1:0] out_char;
  logic [ATTR_W-1:0] out_attr;
  logic [RROW_W-1:0] out_row;
  logic [RCOL_W-1:0] out_col;
  logic              out_scrolled;

  tts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tts_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_cmd_i       (s_axis_tuser[0]),
    .in_char_i      (s_axis_tdata[7:0]),
    .in_row_i       (s_axis_tdata[12:8]),
    .in_col_i       (s_axis_tdata[19:13]),
    .out_char_o     (out_char),
    .out_attr_o     (out_attr),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .out_scrolled_o (out_scrolled)
  );

  assign m_axis_tdata = {3'b000, out_scrolled, out_col, out_row, out_attr, out_char};

endmodule

[tb/text_terminal_cursor_scroll_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_tb
// Self-checking bench for the text console engine. A predictor keeps its own
// screen image, cursor and attribute, works out the result of every accepted
// beat, and the monitor compares each output beat field by field against the
// oldest prediction. Directed tests cover the reset contents, the character
// extremes, out-of-range reads, line feed, carriage return and scrolling;
// random phases with different attributes and idle/stall rates follow.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_tb;
  import tts_pkg::*;

  localparam int COLS        = 80;
  localparam int NROWS       = 25;
  localparam int CLK_HALF    = 2;
  localparam int DRAIN_WAIT  = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 350;

  typedef struct packed {
    logic [2:0]        pad;
    logic              scrolled;
    logic [RCOL_W-1:0] col;
    logic [RROW_W-1:0] row;
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } console_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [ATTR_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predicted console state.
  logic [CHAR_W-1:0] screen_char [NROWS][COLS];
  logic [ATTR_W-1:0] screen_attr [NROWS][COLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] attr_q;

  console_result_t expected_q [$];
  int  errors;
  int  n_puts, n_reads, n_scrolls, n_oor, n_checked;
  int  idle_pct, stall_pct;
  longint cycles;

  text_terminal_cursor_scroll #(.COLUMNS(COLS), .ROWS(NROWS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Output monitor: one prediction is consumed per output beat.
  always @(posedge clk_i) begin
    console_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = console_result_t'(m_axis_tdata[28:0]);
      got.pad = m_axis_tdata[31:29];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got.chr !== want.chr) begin
          $display("%0t: cell_char expected %h actual %h", $time, want.chr, got.chr);
          errors++;
        end
        if (got.attr !== want.attr) begin
          $display("%0t: cell_attr expected %h actual %h", $time, want.attr, got.attr);
          errors++;
        end
        if (got.row !== want.row) begin
          $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
          errors++;
        end
        if (got.col !== want.col) begin
          $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, got.col);
          errors++;
        end
        if (got.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time, want.scrolled,
                   got.scrolled);
          errors++;
        end
        if (got.pad !== 3'b000) begin
          $display("%0t: padding expected 000 actual %b", $time, got.pad);
          errors++;
        end
      end
    end
  end

  function automatic void scroll_screen();
    for (int r = 0; r < NROWS - 1; r++) begin
      for (int c = 0; c < COLS; c++) begin
        screen_char[r][c] = screen_char[r+1][c];
        screen_attr[r][c] = screen_attr[r+1][c];
      end
    end
    for (int c = 0; c < COLS; c++) begin
      screen_char[NROWS-1][c] = CH_SPACE;
      screen_attr[NROWS-1][c] = attr_q;
    end
  endfunction

  function automatic console_result_t predict_console(logic cmd, logic [CHAR_W-1:0] ch,
                                                      logic [RROW_W-1:0] rrow,
                                                      logic [RCOL_W-1:0] rcol);
    console_result_t res;
    res = '0;
    if (cmd == CMD_READ) begin
      if (rrow < NROWS && rcol < COLS) begin
        res.chr  = screen_char[rrow][rcol];
        res.attr = screen_attr[rrow][rcol];
      end
    end else if (ch == CH_CR) begin
      cur_col = 0;
    end else begin
      if (ch == CH_LF) begin
        cur_row++;
        cur_col = 0;
      end else begin
        screen_char[cur_row][cur_col] = ch;
        screen_attr[cur_row][cur_col] = attr_q;
        cur_col++;
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
      end
      if (cur_row >= NROWS) begin
        scroll_screen();
        cur_row = NROWS - 1;
        res.scrolled = 1'b1;
      end
    end
    res.row = cur_row[RROW_W-1:0];
    res.col = cur_col[RCOL_W-1:0];
    return res;
  endfunction

  task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                           input logic [RROW_W-1:0] rrow, input logic [RCOL_W-1:0] rcol);
    console_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0000, rcol, rrow, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_console(cmd, ch, rrow, rcol);
    expected_q.push_back(res);
    if (cmd == CMD_READ) begin
      n_reads++;
      if (rrow >= NROWS || rcol >= COLS) n_oor++;
    end else begin
      n_puts++;
      if (res.scrolled) n_scrolls++;
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(CMD_PUT, ch, RROW_W'($urandom), RCOL_W'($urandom));
  endtask

  task automatic read_cell(input logic [RROW_W-1:0] rrow, input logic [RCOL_W-1:0] rcol);
    send_item(CMD_READ, CHAR_W'($urandom), rrow, rcol);
  endtask

  // Drop the stream and let every outstanding beat come back.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    attr_q = value;
  endtask

  task automatic test_reset_contents();
    read_cell(RROW_W'(0), RCOL_W'(0));
    read_cell(RROW_W'(NROWS - 1), RCOL_W'(COLS - 1));
  endtask

  task automatic test_char_extremes();
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(RROW_W'(0), RCOL_W'(0));
    read_cell(RROW_W'(0), RCOL_W'(1));
    put_char(CH_CR);
    read_cell(RROW_W'(0), RCOL_W'(2));
  endtask

  task automatic test_out_of_range_reads();
    read_cell(5'd31, 7'd0);
    read_cell(5'd0, 7'd127);
    read_cell(RROW_W'(NROWS), RCOL_W'(COLS - 1));
    read_cell(RROW_W'(NROWS - 1), RCOL_W'(COLS));
  endtask

  // Line feeds down to the bottom row, a carriage return there (no scroll),
  // then one more line feed that scrolls the screen.
  task automatic test_line_feed_scroll();
    put_char("A");
    for (int i = 0; i < NROWS - 1; i++) put_char(CH_LF);
    put_char(CH_CR);
    put_char(CH_LF);
    read_cell(RROW_W'(0), RCOL_W'(0));
  endtask

  // Random traffic: mostly printable text with line breaks and read-backs
  // of recently written cells, plus long lines that wrap at the bottom.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(999);
      if (pick < 5) begin
        burst = $urandom_range(120, 40);
        for (int i = 0; i < burst; i++) put_char(8'($urandom_range(126, 32)));
        sent += burst;
      end else begin
        if (pick < 200) begin
          read_cell(RROW_W'(($urandom_range(1) != 0) ? cur_row : $urandom_range(NROWS - 1)),
                    RCOL_W'($urandom_range(COLS - 1)));
        end else if (pick < 250) begin
          read_cell(RROW_W'($urandom), RCOL_W'($urandom));
        end else if (pick < 300) begin
          put_char(CH_CR);
        end else if (pick < 400) begin
          put_char(CH_LF);
        end else if (pick < 550) begin
          put_char(8'($urandom_range(255)));
        end else begin
          put_char(8'($urandom_range(126, 32)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr [4];
    int phase_idle [4];
    int phase_stall [4];
    phase_attr  = '{8'h00, 8'hFF, 8'h00, 8'h5A};
    phase_idle  = '{0, 59, 0, 34};
    phase_stall = '{0, 0, 59, 34};
    phase_attr[2] = 8'($urandom);
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    cur_row = 0;
    cur_col = 0;
    attr_q = ATTR_RESET;
    for (int r = 0; r < NROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        screen_char[r][c] = CH_SPACE;
        screen_attr[r][c] = ATTR_RESET;
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_char_extremes();
    test_out_of_range_reads();
    test_line_feed_scroll();

    for (int p = 0; p < 4; p++) begin
      idle_pct = 0;
      stall_pct = 0;
      write_attr(phase_attr[p]);
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      test_random_traffic(PHASE_ITEMS);
    end

    idle_pct = 0;
    wait_idle();
    stall_pct = 0;
    if (expected_q.size() != 0) begin
      $display("%0t: %0d predicted beats never arrived", $time, expected_q.size());
      errors++;
    end

    $display("Checked %0d beats: %0d puts, %0d of them scrolling; %0d reads, %0d out of range.",
             n_checked, n_puts, n_scrolls, n_reads, n_oor);
    $display("Four attribute settings, idle and stall rates of 0, 34 and 59 percent.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
